// ===== rtl/core/lsdps_pkg.sv =====
// Package: shared types, command codes and sequence constants for the LED pin sequencer.
package lsdps_pkg;

  localparam int CMD_W      = 2;
  localparam int PATTERN_W  = 8;
  localparam int WORD_W     = 8;
  localparam int STEP_W     = 6;
  localparam int GAIN_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONFIG = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN  = 2'd1;

  localparam logic [STEP_W-1:0] LEN_WRITE  = 6'd18;
  localparam logic [STEP_W-1:0] LEN_CONFIG = 6'd36;
  localparam logic [STEP_W-1:0] LEN_READ   = 6'd26;

  // Phase boundaries, in ticks
  localparam logic [STEP_W-1:0] WR_LATCH_TICK = 6'd16;
  localparam logic [STEP_W-1:0] MODE_TICKS    = 6'd10;
  localparam logic [STEP_W-1:0] CFG_NORM_TICK = 6'd26;
  localparam logic [STEP_W-1:0] RD_LAST_LOW   = 6'd14;

  // Per-clock pin levels of the mode switch sequences, bit k = clock k
  localparam logic [4:0] SPEC_OE = 5'b11101;
  localparam logic [4:0] SPEC_LE = 5'b01000;
  localparam logic [4:0] NORM_OE = 5'b11101;
  localparam logic [4:0] READ_OE = 5'b00001;

  typedef struct packed {
    logic              clk_level;
    logic              sdi_level;
    logic              le_level;
    logic              oe_level;
    logic              busy_res;
    logic              error_valid;
    logic [WORD_W-1:0] error_flags;
  } result_t;

endpackage

// ===== rtl/core/lsdps_if.sv =====
// Interfaces: tick input, pin result and configuration write channels.
interface lsdps_in_if;
  logic                                valid;
  logic                                ready;
  logic [lsdps_pkg::CMD_W-1:0]         cmd;
  logic [lsdps_pkg::PATTERN_W-1:0]     pattern;
  logic                                sdo_level;

  modport source (output valid, output cmd, output pattern, output sdo_level, input ready);
  modport sink   (input valid, input cmd, input pattern, input sdo_level, output ready);
endinterface

interface lsdps_out_if;
  logic                                valid;
  logic                                ready;
  logic                                clk_level;
  logic                                sdi_level;
  logic                                le_level;
  logic                                oe_level;
  logic                                busy_res;
  logic                                error_valid;
  logic [lsdps_pkg::WORD_W-1:0]        error_flags;

  modport source (output valid, output clk_level, output sdi_level, output le_level,
                  output oe_level, output busy_res, output error_valid,
                  output error_flags, input ready);
  modport sink   (input valid, input clk_level, input sdi_level, input le_level,
                  input oe_level, input busy_res, input error_valid,
                  input error_flags, output ready);
endinterface

interface lsdps_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lsdps_pkg::CFG_IDX_W-1:0]     index;
  logic [lsdps_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/led_sink_driver_pin_sequencer_top.sv =====
// Top level: tick-by-tick pin sequencer for an 8-channel serial LED sink driver.
//
//  channel  | dir | payload                                      | transfer when
//  ---------+-----+----------------------------------------------+-------------------
//  in_if    | in  | cmd, pattern, sdo_level                      | valid && ready
//  out_if   | out | clk/sdi/le/oe levels, busy_res, error_valid, | valid && ready
//           |     | error_flags                                  |
//  cfg_if   | in  | index, data                                  | valid && ready
//
// One tick per cycle while out_if is not stalled: each input transfer is decoded
// in one pass against the sequence state and lands in the result register the
// next cycle. in_ready is high whenever the result register is empty or is being
// drained, so ticks flow back to back; a stalled out_if holds the result and in_if.
// cfg_if is always ready. Reset (rst_n low, synchronous) returns to idle with
// oe high, sdi low and the config word at 0xFF.
module led_sink_driver_pin_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  lsdps_in_if.sink    in_if,
  lsdps_out_if.source out_if,
  lsdps_cfg_if.sink   cfg_if
);

  // Config registers
  logic                                 current_range_r;
  logic [lsdps_pkg::GAIN_W-1:0]         voltage_gain_r;

  // Sequence state
  logic [lsdps_pkg::CMD_W-1:0]          active_r, active_nxt;
  logic [lsdps_pkg::STEP_W-1:0]         step_r, step_nxt;
  logic [lsdps_pkg::WORD_W-1:0]         shift_r, shift_nxt;
  logic [lsdps_pkg::WORD_W-1:0]         err_r, err_nxt;
  logic                                 oe_hold_r;
  logic                                 sdi_hold_r;

  // Result register
  logic                                 out_valid_r;
  lsdps_pkg::result_t                   out_r, res_nxt;

  logic                                 in_xfer;
  logic                                 start;
  logic [lsdps_pkg::CMD_W-1:0]          act;
  logic [lsdps_pkg::STEP_W-1:0]         t;
  logic [lsdps_pkg::STEP_W-1:0]         u;
  logic [lsdps_pkg::STEP_W-1:0]         t_inc;
  logic [lsdps_pkg::STEP_W-1:0]         len;
  logic [2:0]                           k;
  logic [2:0]                           ku;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign start = (active_r == lsdps_pkg::CMD_NONE) && (in_if.cmd != lsdps_pkg::CMD_NONE);
  assign act   = start ? in_if.cmd : active_r;
  assign t     = start ? '0 : step_r;
  assign k     = t[3:1];
  assign t_inc = t + 6'd1;

  // Tick decode
  always_comb begin
    // command capture on start
    shift_nxt = shift_r;
    err_nxt   = err_r;
    if (start) begin
      case (in_if.cmd)
        lsdps_pkg::CMD_WRITE:  shift_nxt = in_if.pattern;
        lsdps_pkg::CMD_CONFIG: shift_nxt = {current_range_r, voltage_gain_r};
        lsdps_pkg::CMD_READ:   err_nxt   = '0;
        default:               shift_nxt = shift_r;
      endcase
    end

    // idle levels
    res_nxt.clk_level   = 1'b0;
    res_nxt.sdi_level   = sdi_hold_r;
    res_nxt.le_level    = 1'b0;
    res_nxt.oe_level    = oe_hold_r;
    res_nxt.busy_res    = (act != lsdps_pkg::CMD_NONE);
    res_nxt.error_valid = 1'b0;
    u   = '0;
    ku  = '0;
    len = '0;

    case (act)
      lsdps_pkg::CMD_WRITE: begin
        len = lsdps_pkg::LEN_WRITE;
        if (t < lsdps_pkg::WR_LATCH_TICK) begin
          res_nxt.clk_level = t[0];
          res_nxt.sdi_level = shift_nxt[3'd7 - k];
        end else if (t == lsdps_pkg::WR_LATCH_TICK) begin
          res_nxt.le_level = 1'b1;
        end else begin
          res_nxt.oe_level = 1'b0;
        end
      end
      lsdps_pkg::CMD_CONFIG: begin
        len = lsdps_pkg::LEN_CONFIG;
        if (t < lsdps_pkg::MODE_TICKS) begin
          res_nxt.clk_level = t[0];
          res_nxt.oe_level  = lsdps_pkg::SPEC_OE[k];
          res_nxt.le_level  = lsdps_pkg::SPEC_LE[k];
        end else if (t < lsdps_pkg::CFG_NORM_TICK) begin
          u  = t - lsdps_pkg::MODE_TICKS;
          ku = u[3:1];
          res_nxt.clk_level = u[0];
          res_nxt.sdi_level = shift_nxt[ku];
          res_nxt.le_level  = (ku == 3'd7);
          res_nxt.oe_level  = 1'b1;
        end else begin
          u  = t - lsdps_pkg::CFG_NORM_TICK;
          ku = u[3:1];
          res_nxt.clk_level = u[0];
          res_nxt.oe_level  = lsdps_pkg::NORM_OE[ku];
        end
      end
      lsdps_pkg::CMD_READ: begin
        len = lsdps_pkg::LEN_READ;
        if (t < lsdps_pkg::MODE_TICKS) begin
          res_nxt.clk_level = t[0];
          res_nxt.oe_level  = lsdps_pkg::READ_OE[k];
        end else begin
          u = t - lsdps_pkg::MODE_TICKS;
          res_nxt.clk_level = u[0];
          res_nxt.oe_level  = 1'b1;
          if (!u[0]) begin
            // sample sdo on the clock-low tick
            err_nxt = {err_nxt[lsdps_pkg::WORD_W-2:0], in_if.sdo_level};
            res_nxt.error_valid = (u == lsdps_pkg::RD_LAST_LOW);
          end
        end
      end
      default: len = '0;
    endcase

    res_nxt.error_flags = err_nxt;

    // advance
    if (act == lsdps_pkg::CMD_NONE) begin
      step_nxt   = step_r;
      active_nxt = active_r;
    end else if (t_inc >= len) begin
      step_nxt   = '0;
      active_nxt = lsdps_pkg::CMD_NONE;
    end else begin
      step_nxt   = t_inc;
      active_nxt = act;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_range_r <= 1'b1;
      voltage_gain_r  <= '1;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        lsdps_pkg::REG_CURRENT_RANGE: current_range_r <= cfg_if.data[0];
        lsdps_pkg::REG_VOLTAGE_GAIN:  voltage_gain_r  <= cfg_if.data[lsdps_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= lsdps_pkg::CMD_NONE;
      step_r     <= '0;
      shift_r    <= '0;
      err_r      <= '0;
      oe_hold_r  <= 1'b1;
      sdi_hold_r <= 1'b0;
    end else if (in_xfer) begin
      active_r   <= active_nxt;
      step_r     <= step_nxt;
      shift_r    <= shift_nxt;
      err_r      <= err_nxt;
      oe_hold_r  <= res_nxt.oe_level;
      sdi_hold_r <= res_nxt.sdi_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      out_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_r <= res_nxt;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.clk_level   = out_r.clk_level;
  assign out_if.sdi_level   = out_r.sdi_level;
  assign out_if.le_level    = out_r.le_level;
  assign out_if.oe_level    = out_r.oe_level;
  assign out_if.busy_res    = out_r.busy_res;
  assign out_if.error_valid = out_r.error_valid;
  assign out_if.error_flags = out_r.error_flags;

  // Idle means step counter parked at zero
  a_idle_step_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r == lsdps_pkg::CMD_NONE) |-> (step_r == '0))
    else $error("step counter nonzero while idle");

  // Step counter stays inside the running sequence
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((active_r == lsdps_pkg::CMD_WRITE)  && (step_r < lsdps_pkg::LEN_WRITE))  ||
    ((active_r == lsdps_pkg::CMD_CONFIG) && (step_r < lsdps_pkg::LEN_CONFIG)) ||
    ((active_r == lsdps_pkg::CMD_READ)   && (step_r < lsdps_pkg::LEN_READ))   ||
    (active_r == lsdps_pkg::CMD_NONE))
    else $error("step counter beyond sequence length");

  // A command on an idle tick is latched as the running command
  a_start_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && start) |=> (active_r == $past(in_if.cmd)) || (active_r == lsdps_pkg::CMD_NONE))
    else $error("started command not captured");

  // Error byte completion only on a busy clock-low tick
  a_err_valid_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.error_valid) |-> (out_r.busy_res && !out_r.clk_level))
    else $error("error_valid outside a read sample tick");

  // Idle ticks keep the clock and latch low
  a_idle_pins: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.busy_res) |-> (!out_r.clk_level && !out_r.le_level))
    else $error("clock or latch active on idle tick");

endmodule
